>>> src/vpms_pkg.sv
// ----------------------------------------------------------------------------
// vpms_pkg
// Shared widths, limits and the state type of the visible pairs counter.
// ----------------------------------------------------------------------------
`default_nettype none

package vpms_pkg;

  localparam int HEIGHT_W = 31;
  localparam int PAIRS_W  = 13;
  localparam int TOTAL_W  = 63;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } vpms_state_t;

endpackage

`default_nettype wire

>>> src/vpms_stack_mem.sv
// ----------------------------------------------------------------------------
// vpms_stack_mem
// Stack storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vpms_stack_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/vpms_search.sv
// ----------------------------------------------------------------------------
// vpms_search
// Two interleaved binary searches over the stack that share one comparator.
// Search A counts the entries taller than the height, search B the entries
// at least as tall. Reads alternate between them, so the memory is read on
// every cycle while both searches are still running.
// ----------------------------------------------------------------------------
`default_nettype none

module vpms_search
  import vpms_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic [$clog2(DEPTH+1)-1:0] size,
  input  wire logic [HEIGHT_W-1:0]        height,
  output logic      [$clog2(DEPTH)-1:0]   raddr,
  input  wire logic [HEIGHT_W-1:0]        rdata,
  output logic                            done,
  output logic      [$clog2(DEPTH+1)-1:0] cnt_gt,
  output logic      [$clog2(DEPTH+1)-1:0] cnt_ge
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic          busy;
  logic          phase;
  logic          pend_v;
  logic          pend_sel;
  logic [CW-1:0] pend_mid;
  logic [CW-1:0] lo_a, hi_a, lo_b, hi_b;

  logic          done_a, done_b;
  logic [CW:0]   sum_a, sum_b;
  logic [CW-1:0] mid_a, mid_b, mid_sel;
  logic          issue_v;
  logic          pred;
  logic          finish;

  always_comb begin
    done_a  = (lo_a == hi_a);
    done_b  = (lo_b == hi_b);
    sum_a   = {1'b0, lo_a} + {1'b0, hi_a};
    sum_b   = {1'b0, lo_b} + {1'b0, hi_b};
    mid_a   = sum_a[CW:1];
    mid_b   = sum_b[CW:1];
    mid_sel = phase ? mid_b : mid_a;
    issue_v = busy && !(phase ? done_b : done_a);
    raddr   = mid_sel[AW-1:0];
    // Search A looks for taller entries, search B also takes equal ones.
    pred    = (rdata > height) || (pend_sel && (rdata == height));
    finish  = busy && done_a && done_b && !pend_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pend_v <= 1'b0;
      done   <= 1'b0;
      phase  <= 1'b0;
    end else begin
      done <= finish;
      if (go) begin
        busy   <= 1'b1;
        pend_v <= 1'b0;
        phase  <= 1'b0;
        lo_a   <= '0;
        hi_a   <= size;
        lo_b   <= '0;
        hi_b   <= size;
      end else if (busy) begin
        phase    <= ~phase;
        pend_v   <= issue_v;
        pend_sel <= phase;
        pend_mid <= mid_sel;
        if (pend_v) begin
          if (!pend_sel) begin
            if (pred) begin
              lo_a <= pend_mid + CW'(1);
            end else begin
              hi_a <= pend_mid;
            end
          end else begin
            if (pred) begin
              lo_b <= pend_mid + CW'(1);
            end else begin
              hi_b <= pend_mid;
            end
          end
        end
        if (finish) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign cnt_gt = lo_a;
  assign cnt_ge = lo_b;

endmodule

`default_nettype wire

>>> src/visible_pairs_monotonic_stack.sv
// ----------------------------------------------------------------------------
// visible_pairs_monotonic_stack
// Counts the pairs of heights in a stream that can see each other, using a
// non-increasing stack held in memory and a shared binary search unit.
// ----------------------------------------------------------------------------
// A start beat goes from acceptance straight to the result register; any other
// beat first runs the search, which takes longer as the stack grows; the one
// memory read port, shared by two interleaved searches, sets how long the
// search takes. The block takes one beat at a time: the next is taken in the
// cycle after the result is loaded, and loading waits for a free output.
// Reset empties the stack and clears the total; the memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module visible_pairs_monotonic_stack
  import vpms_pkg::*;
#(
  parameter int STACK_DEPTH = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire logic [HEIGHT_W-1:0] height,
  input  wire logic                start_req,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output logic      [PAIRS_W-1:0]  new_pairs,
  output logic      [TOTAL_W-1:0]  total_pairs,
  output logic                     overflow
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  vpms_state_t state, state_next;

  logic [HEIGHT_W-1:0] h_reg;
  logic [CW-1:0]       size;
  logic [TOTAL_W-1:0]  total;
  logic [CW-1:0]       res_pairs;
  logic                res_ovf;

  logic                accept;
  logic                srch_go;
  logic                load_out;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [HEIGHT_W-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [HEIGHT_W-1:0] mem_rdata;
  logic                srch_done;
  logic [CW-1:0]       cnt_gt, cnt_ge;

  logic [CW-1:0]       k_idx;
  logic [CW-1:0]       pairs_calc;
  logic                ovf_calc;
  logic [TOTAL_W:0]    total_sum;
  logic [TOTAL_W-1:0]  total_calc;

  vpms_stack_mem #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(HEIGHT_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  vpms_search #(
    .DEPTH(STACK_DEPTH)
  ) u_search (
    .clk   (clk),
    .rst   (rst),
    .go    (srch_go),
    .size  (size),
    .height(h_reg),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .done  (srch_done),
    .cnt_gt(cnt_gt),
    .cnt_ge(cnt_ge)
  );

  always_comb begin
    k_idx      = (cnt_gt == '0) ? '0 : cnt_gt - CW'(1);
    pairs_calc = size - k_idx;
    ovf_calc   = (cnt_ge == CW'(STACK_DEPTH));
    total_sum  = {1'b0, total} + (TOTAL_W + 1)'(pairs_calc);
    total_calc = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = start_req ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cnt_ge[AW-1:0];
    mem_wdata  = h_reg;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid && start_req) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = height;
        end
      end
      ST_SEARCH: begin
        mem_we = srch_done && !ovf_calc;
      end
      ST_FINISH: begin
        load_out = !result_valid || result_ready;
      end
      default: ;
    endcase
  end

  assign accept  = item_valid && item_ready;
  assign srch_go = accept && !start_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      size         <= '0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        h_reg <= height;
        if (start_req) begin
          size      <= CW'(1);
          total     <= '0;
          res_pairs <= '0;
          res_ovf   <= 1'b0;
        end
      end
      if (state == ST_SEARCH && srch_done) begin
        res_pairs <= pairs_calc;
        res_ovf   <= ovf_calc;
        total     <= total_calc;
        size      <= ovf_calc ? cnt_ge : cnt_ge + CW'(1);
      end
      if (load_out) begin
        result_valid <= 1'b1;
        new_pairs    <= PAIRS_W'(res_pairs);
        total_pairs  <= total;
        overflow     <= res_ovf;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/visible_pairs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// visible_pairs_checker
// Watches both channels of the visible pairs counter. It keeps its own copy
// of the height stack and the running total and works out the result of each
// accepted input beat. Each result beat is then compared, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module visible_pairs_checker
  import vpms_pkg::*;
#(
  parameter int STACK_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  logic [HEIGHT_W-1:0] height,
  input  logic                start_req,
  input  logic                result_valid,
  input  logic                result_ready,
  input  logic [PAIRS_W-1:0]  new_pairs,
  input  logic [TOTAL_W-1:0]  total_pairs,
  input  logic                overflow,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen,
  output int                  overflow_seen,
  output int                  peak_depth
);

  typedef struct packed {
    logic [PAIRS_W-1:0] pairs;
    logic [TOTAL_W-1:0] total;
    logic               ovf;
  } pair_result_t;

  logic [HEIGHT_W-1:0] tower [STACK_DEPTH];
  int                  depth_used;
  logic [TOTAL_W-1:0]  pair_total;
  pair_result_t        pairs_due [$];

  task automatic count_new_pairs(input logic [HEIGHT_W-1:0] h, input logic fresh);
    pair_result_t r;
    int           taller;
    int           pairs;
    r = '0;
    if (fresh) begin
      pair_total = '0;
      tower[0] = h;
      depth_used = 1;
    end else begin
      // The stack never increases from bottom to top, so the entries taller
      // than h form a prefix of it.
      taller = 0;
      while (taller < depth_used && tower[taller] > h) taller++;
      pairs = depth_used - ((taller == 0) ? 0 : taller - 1);
      if (TOTAL_MAX - pair_total < TOTAL_W'(pairs)) begin
        pair_total = TOTAL_MAX;
      end else begin
        pair_total = pair_total + TOTAL_W'(pairs);
      end
      while (depth_used > 0 && tower[depth_used-1] < h) depth_used--;
      if (depth_used >= STACK_DEPTH) begin
        r.ovf = 1'b1;
        overflow_seen++;
      end else begin
        tower[depth_used] = h;
        depth_used++;
      end
      r.pairs = PAIRS_W'(pairs);
    end
    r.total = pair_total;
    if (depth_used > peak_depth) peak_depth = depth_used;
    pairs_due = {pairs_due, r};
  endtask

  always @(posedge clk) begin
    pair_result_t due;
    if (rst) begin
      depth_used = 0;
      pair_total = '0;
      pairs_due.delete();
      fail_count = 0;
      results_seen = 0;
      overflow_seen = 0;
      peak_depth = 0;
      pending = 0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (pairs_due.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, new_pairs %0d total %0d",
                   $time, new_pairs, total_pairs);
          fail_count++;
        end else begin
          due = pairs_due.pop_front();
          if (new_pairs !== due.pairs) begin
            $display("%0t: new_pairs mismatch, expected %0d, actual %0d",
                     $time, due.pairs, new_pairs);
            fail_count++;
          end
          if (total_pairs !== due.total) begin
            $display("%0t: total_pairs mismatch, expected %0d, actual %0d",
                     $time, due.total, total_pairs);
            fail_count++;
          end
          if (overflow !== due.ovf) begin
            $display("%0t: overflow mismatch, expected %0d, actual %0d",
                     $time, due.ovf, overflow);
            fail_count++;
          end
        end
      end
      if (item_valid && item_ready) count_new_pairs(height, start_req);
      pending = pairs_due.size();
    end
  end

endmodule

>>> tb/visible_pairs_monotonic_stack_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// visible_pairs_monotonic_stack_tb
// Drives height beats into the visible pairs counter and drains its results
// with random gaps on both sides. A short directed part hits the edge cases,
// a long non-increasing run fills the stack to overflow, and random sequences
// of several height shapes follow. A separate checker predicts and compares.
// ----------------------------------------------------------------------------

module visible_pairs_monotonic_stack_tb;
  import vpms_pkg::*;

  localparam int DEPTH = 4096;
  localparam logic [HEIGHT_W-1:0] HMAX = {HEIGHT_W{1'b1}};

  typedef enum int {
    H_TINY,
    H_WIDE,
    H_DRIFT,
    H_EDGE
  } height_mode_t;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  logic [HEIGHT_W-1:0] height;
  logic                start_req;
  logic                result_valid;
  logic                result_ready;
  logic [PAIRS_W-1:0]  new_pairs;
  logic [TOTAL_W-1:0]  total_pairs;
  logic                overflow;

  int fail_count;
  int pending;
  int results_seen;
  int overflow_seen;
  int peak_depth;

  int beats_sent;
  int starts_sent;
  bit idle_on;

  visible_pairs_monotonic_stack #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .height(height),
    .start_req(start_req),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .new_pairs(new_pairs),
    .total_pairs(total_pairs),
    .overflow(overflow)
  );

  visible_pairs_checker #(
    .STACK_DEPTH(DEPTH)
  ) chk (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .height(height),
    .start_req(start_req),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .new_pairs(new_pairs),
    .total_pairs(total_pairs),
    .overflow(overflow),
    .fail_count(fail_count),
    .pending(pending),
    .results_seen(results_seen),
    .overflow_seen(overflow_seen),
    .peak_depth(peak_depth)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_beat(input logic [HEIGHT_W-1:0] h, input logic s);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    height <= h;
    start_req <= s;
    do @(posedge clk); while (!item_ready);
    beats_sent++;
    if (s) starts_sent++;
  endtask

  // Keeps draining results; a long hold-off early on (and rarely later) lets
  // the block fill up and stall its input while beats keep being offered.
  task automatic drain_results();
    int  got;
    int  stall;
    bit  calm;
    got = 0;
    calm = 1'b0;
    result_ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(result_valid && result_ready));
      got++;
      if (got % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (got == 30 || $urandom_range(0, 499) == 0) begin
        stall = 300;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        result_ready <= 1'b1;
      end
    end
  endtask

  function automatic logic [HEIGHT_W-1:0] pick_height(height_mode_t mode,
                                                       logic [HEIGHT_W-1:0] prev);
    logic [HEIGHT_W-1:0] h;
    case (mode)
      H_TINY: begin
        h = HEIGHT_W'($urandom_range(0, 15));
      end
      H_WIDE: begin
        h = HEIGHT_W'($urandom());
      end
      H_DRIFT: begin
        if ($urandom_range(0, 15) == 0) begin
          h = prev + HEIGHT_W'($urandom_range(1, 40));
        end else begin
          h = (prev >= 3) ? prev - HEIGHT_W'($urandom_range(0, 3)) : prev;
        end
      end
      default: begin
        case ($urandom_range(0, 3))
          0: h = '0;
          1: h = HMAX;
          2: h = HMAX - 31'd1;
          default: h = HEIGHT_W'($urandom());
        endcase
      end
    endcase
    return h;
  endfunction

  initial begin
    logic [HEIGHT_W-1:0] h;
    logic [HEIGHT_W-1:0] base;
    height_mode_t        mode;
    int                  rand_beats;
    int                  seq_len;
    bit                  noisy;
    logic                s;

    rst <= 1'b1;
    item_valid <= 1'b0;
    height <= '0;
    start_req <= 1'b0;
    result_ready <= 1'b0;
    beats_sent = 0;
    starts_sent = 0;
    idle_on = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    send_beat(31'd5, 1'b0);
    send_beat('0, 1'b0);
    send_beat(HMAX, 1'b0);
    send_beat(HMAX, 1'b1);
    send_beat('0, 1'b1);
    send_beat(31'd7, 1'b0);
    send_beat(31'd7, 1'b0);
    send_beat(31'd7, 1'b0);
    send_beat(HMAX, 1'b0);
    send_beat(HMAX, 1'b0);
    send_beat(31'h2AAA_AAAA, 1'b1);
    send_beat(31'h5555_5555, 1'b0);
    send_beat(31'h5555_5554, 1'b0);
    send_beat(31'h5555_5556, 1'b0);
    send_beat('0, 1'b0);
    send_beat(31'd1, 1'b0);
    send_beat(HMAX - 31'd1, 1'b0);
    send_beat('0, 1'b1);
    send_beat('0, 1'b0);

    base = 31'd2_000_000_000;
    send_beat(base, 1'b1);
    for (int i = 0; i < DEPTH + 10; i++) begin
      send_beat(base - 31'((i / 3) * 7), 1'b0);
    end
    send_beat(base - 31'd9600, 1'b0);
    send_beat(base - 31'd5000, 1'b0);
    send_beat(HMAX, 1'b0);
    send_beat('0, 1'b0);

    rand_beats = 0;
    while (rand_beats < 2000) begin
      seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                            : $urandom_range(1, 60);
      mode = height_mode_t'($urandom_range(0, 3));
      noisy = ($urandom_range(0, 7) == 0);
      idle_on = ($urandom_range(0, 3) != 0);
      h = pick_height(H_WIDE, '0);
      for (int i = 0; i < seq_len; i++) begin
        h = pick_height(mode, h);
        s = noisy ? ($urandom_range(0, 3) == 0) : (i == 0);
        send_beat(h, s);
      end
      rand_beats += seq_len;
    end
    item_valid <= 1'b0;

    wait (results_seen >= beats_sent);
    repeat (40) @(posedge clk);
    $display("Sent %0d beats (%0d starting a sequence), checked %0d results.",
             beats_sent, starts_sent, results_seen);
    $display("Peak stack depth %0d, %0d pushes dropped on a full stack.",
             peak_depth, overflow_seen);
    if (pending != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/vpms_pkg.sv
src/vpms_stack_mem.sv
src/vpms_search.sv
src/visible_pairs_monotonic_stack.sv
tb/visible_pairs_checker.sv
tb/visible_pairs_monotonic_stack_tb.sv
